[rtl/dmm_pkg.sv]
package dmm_pkg;

    // Default values for the top-level parameters.
    localparam int unsigned MAX_DIM_DEFAULT   = 8;
    localparam int unsigned FRAC_BITS_DEFAULT = 30;

    // Fixed field widths.
    localparam int unsigned ELEM_W    = 32;
    localparam int unsigned CFG_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned POS_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 4'd5;
    localparam logic [CFG_W-1:0] INNER_LEN_RESET = 4'd7;
    localparam logic [CFG_W-1:0] COL_COUNT_RESET = 4'd5;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COMPUTE,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic             issue;
        logic             first;
        logic             last_term;
        logic             last_elem;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
    } t_status;

    // A dimension of zero acts as one, any value above the maximum acts as the maximum.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int unsigned max_dim);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (32'(v) > max_dim) begin
            res = CFG_W'(max_dim);
        end
        return res;
    endfunction

endpackage

[rtl/dmm_ram.sv]
module dmm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dmm_ctrl.sv]
module dmm_ctrl #(
    parameter int unsigned MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dmm_pkg::CFG_W-1:0]            i_cfg_data,
    output dmm_pkg::t_cmd                        o_cmd,
    input  dmm_pkg::t_status                     i_status,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_waddr,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_raddr_a,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_raddr_b
);
    import dmm_pkg::*;

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned PW    = $clog2(DEPTH + 1);
    localparam int unsigned DW    = $clog2(MAX_DIM + 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_row_count, r_inner_len, r_col_count;
    logic [AW-1:0]    r_load_count, n_load_count;
    logic             r_loading_b, n_loading_b;

    logic [DW-1:0]    r_row, n_row, r_col, n_col, r_k, n_k;
    logic [AW-1:0]    r_a_base, n_a_base, r_b_base, n_b_base;

    logic [DW-1:0]    rows, inner, cols;
    logic [PW-1:0]    total_a, total_b, count_inc;
    logic             accept, cfg_write, cfg_known;
    logic             load_done_a, load_done_b;
    logic             last_term, last_col, last_row, last_tuple;

    assign rows  = DW'(clamp_dim(r_row_count, MAX_DIM));
    assign inner = DW'(clamp_dim(r_inner_len, MAX_DIM));
    assign cols  = DW'(clamp_dim(r_col_count, MAX_DIM));

    assign total_a   = PW'(rows) * PW'(inner);
    assign total_b   = PW'(inner) * PW'(cols);
    assign count_inc = PW'(r_load_count) + PW'(1);

    assign accept    = i_start && !o_busy;
    assign cfg_write = i_cfg_valid && o_cfg_ready;
    assign cfg_known = (i_cfg_index == REG_ROW_COUNT) || (i_cfg_index == REG_INNER_LEN)
                    || (i_cfg_index == REG_COL_COUNT);

    assign load_done_a = accept && !r_loading_b && (count_inc >= total_a);
    assign load_done_b = accept &&  r_loading_b && (count_inc >= total_b);

    assign last_term  = (r_k   == inner - DW'(1));
    assign last_col   = (r_col == cols  - DW'(1));
    assign last_row   = (r_row == rows  - DW'(1));
    assign last_tuple = last_term && last_col && last_row;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RESET;
            r_inner_len <= INNER_LEN_RESET;
            r_col_count <= COL_COUNT_RESET;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_ROW_COUNT: r_row_count <= i_cfg_data;
                REG_INNER_LEN: r_inner_len <= i_cfg_data;
                REG_COL_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Load position.
    always_comb begin
        n_load_count = r_load_count;
        n_loading_b  = r_loading_b;
        priority if (cfg_write && cfg_known) begin
            n_load_count = '0;
            n_loading_b  = 1'b0;
        end else if (load_done_a) begin
            n_load_count = '0;
            n_loading_b  = 1'b1;
        end else if (load_done_b) begin
            n_load_count = '0;
            n_loading_b  = 1'b0;
        end else if (accept) begin
            n_load_count = r_load_count + AW'(1);
        end
    end

    // Compute sequencer: walks row, column and inner term, one term a cycle.
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_k      = r_k;
        n_a_base = r_a_base;
        n_b_base = r_b_base;
        if (r_state != ST_COMPUTE) begin
            n_row    = '0;
            n_col    = '0;
            n_k      = '0;
            n_a_base = '0;
            n_b_base = '0;
        end else if (!last_term) begin
            n_k = r_k + DW'(1);
        end else begin
            n_k = '0;
            if (last_col) begin
                n_col    = '0;
                n_b_base = '0;
                n_row    = r_row + DW'(1);
                n_a_base = r_a_base + AW'(inner);
            end else begin
                n_col    = r_col + DW'(1);
                n_b_base = r_b_base + AW'(inner);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:    if (load_done_b) n_state = ST_COMPUTE;
            ST_COMPUTE: if (last_tuple) n_state = ST_DRAIN;
            ST_DRAIN:   if (!i_status.pipe_busy) n_state = ST_LOAD;
            default:    n_state = ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb begin
        o_busy              = (r_state != ST_LOAD);
        o_cfg_ready         = (r_state == ST_LOAD);
        o_cmd.load_a        = accept && !r_loading_b;
        o_cmd.load_b        = accept &&  r_loading_b;
        o_cmd.issue         = (r_state == ST_COMPUTE);
        o_cmd.first         = (r_k == '0);
        o_cmd.last_term     = last_term;
        o_cmd.last_elem     = last_row && last_col;
        o_cmd.row           = POS_W'(r_row);
        o_cmd.col           = POS_W'(r_col);
        o_waddr             = r_load_count;
        o_raddr_a           = r_a_base + AW'(r_k);
        o_raddr_b           = r_b_base + AW'(r_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_load_count <= '0;
            r_loading_b  <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_k          <= '0;
            r_a_base     <= '0;
            r_b_base     <= '0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_loading_b  <= n_loading_b;
            r_row        <= n_row;
            r_col        <= n_col;
            r_k          <= n_k;
            r_a_base     <= n_a_base;
            r_b_base     <= n_b_base;
        end
    end

endmodule

[rtl/dmm_datapath.sv]
module dmm_datapath #(
    parameter int unsigned MAX_DIM   = dmm_pkg::MAX_DIM_DEFAULT,
    parameter int unsigned FRAC_BITS = dmm_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dmm_pkg::t_cmd                     i_cmd,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_waddr,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_raddr_a,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_raddr_b,
    input  logic signed [dmm_pkg::ELEM_W-1:0] i_element,
    output dmm_pkg::t_status                  o_status,
    output logic                              o_valid,
    output logic signed [dmm_pkg::ELEM_W-1:0] o_product_value,
    output logic [dmm_pkg::POS_W-1:0]         o_out_row,
    output logic [dmm_pkg::POS_W-1:0]         o_out_col,
    output logic                              o_last
);
    import dmm_pkg::*;

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned PRODW = 2 * ELEM_W;
    localparam int unsigned ACCW  = PRODW + $clog2(MAX_DIM) + 1;

    localparam logic signed [ACCW-1:0] HALF   = ACCW'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACCW-1:0] SAT_HI =
        {{(ACCW - ELEM_W + 1){1'b0}}, {(ELEM_W - 1){1'b1}}};
    localparam logic signed [ACCW-1:0] SAT_LO =
        {{(ACCW - ELEM_W + 1){1'b1}}, {(ELEM_W - 1){1'b0}}};

    logic [ELEM_W-1:0] a_rdata, b_rdata;

    logic                    r_v1, r_v2, r_v3, r_v4;
    t_cmd                    r_tag1, r_tag2, r_tag3;
    logic signed [PRODW-1:0] r_prod;
    logic signed [ACCW-1:0]  r_acc, prod_ext, rounded;
    logic signed [ELEM_W-1:0] r_value, sat_value;
    logic [POS_W-1:0]        r_row, r_col;
    logic                    r_last;

    dmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_a),
        .i_waddr (i_waddr),
        .i_wdata (i_element),
        .i_raddr (i_raddr_a),
        .o_rdata (a_rdata)
    );

    dmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_b),
        .i_waddr (i_waddr),
        .i_wdata (i_element),
        .i_raddr (i_raddr_b),
        .o_rdata (b_rdata)
    );

    assign prod_ext = ACCW'(r_prod);
    assign rounded  = (r_acc + HALF) >>> FRAC_BITS;

    always_comb begin
        priority if (rounded > SAT_HI) begin
            sat_value = SAT_HI[ELEM_W-1:0];
        end else if (rounded < SAT_LO) begin
            sat_value = SAT_LO[ELEM_W-1:0];
        end else begin
            sat_value = rounded[ELEM_W-1:0];
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_tag2.last_term;
            r_v4 <= r_v3;
        end
    end

    // Read, multiply, accumulate, round and saturate.
    always_ff @(posedge i_clk) begin
        r_tag1 <= i_cmd;
        r_tag2 <= r_tag1;
        r_prod <= $signed(a_rdata) * $signed(b_rdata);
        if (r_v2) begin
            r_acc  <= r_tag2.first ? prod_ext : r_acc + prod_ext;
            r_tag3 <= r_tag2;
        end
        if (r_v3) begin
            r_value <= sat_value;
            r_row   <= r_tag3.row;
            r_col   <= r_tag3.col;
            r_last  <= r_tag3.last_elem;
        end
    end

    assign o_status.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_valid            = r_v4;
    assign o_product_value    = r_value;
    assign o_out_row          = r_row;
    assign o_out_col          = r_col;
    assign o_last             = r_v4 && r_last;

endmodule

[rtl/dense_matrix_multiply_unit.sv]
// Channel       Direction  Signals                                       Completes when
// element in    in         start, busy, i_element                        start && !busy
// config write  in         i_cfg_valid, o_cfg_ready, i_cfg_index, ...    valid && ready
// result out    out        o_valid, o_product_value, o_out_row/col, ...  every o_valid cycle
//
// Each accepted request loads one element; busy stays low while A and B are loaded.
// The request that completes B starts a burst of rows*cols*inner
// multiply-accumulates, one per cycle through a single 32x32 multiplier,
// followed by a pipeline drain; busy is high for that whole burst.
// Reset is synchronous and active low; it restores the default dimensions and
// restarts loading at the first element of A. The matrix stores are not cleared.
// Results cannot be held off: each one is valid for exactly one cycle.
module dense_matrix_multiply_unit #(
    parameter int unsigned MAX_DIM   = dmm_pkg::MAX_DIM_DEFAULT,
    parameter int unsigned FRAC_BITS = dmm_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Element requests.
    input  logic                               start,
    output logic                               busy,
    input  logic signed [dmm_pkg::ELEM_W-1:0]  i_element,
    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dmm_pkg::CFG_W-1:0]          i_cfg_data,
    // Results.
    output logic                               o_valid,
    output logic signed [dmm_pkg::ELEM_W-1:0]  o_product_value,
    output logic [dmm_pkg::POS_W-1:0]          o_out_row,
    output logic [dmm_pkg::POS_W-1:0]          o_out_col,
    output logic                               o_last
);
    import dmm_pkg::*;

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // The controller owns the dimension registers, the load position and the
    // row/column/term sequencer. The datapath owns both element memories, the
    // multiplier, the accumulator and the rounding and saturation stage.
    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] waddr, raddr_a, raddr_b;

    dmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cmd          (cmd),
        .i_status       (status),
        .o_waddr        (waddr),
        .o_raddr_a      (raddr_a),
        .o_raddr_b      (raddr_b)
    );

    dmm_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_waddr         (waddr),
        .i_raddr_a       (raddr_a),
        .i_raddr_b       (raddr_b),
        .i_element       (i_element),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_product_value (o_product_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last          (o_last)
    );

endmodule

[rtl/dmm_checker.sv]
module dmm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_cfg_ready,
    input logic                              o_valid,
    input logic                              o_last
);

    // A result only appears inside a compute burst.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result outside a compute burst");

    // Configuration is refused while a burst runs.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready)
        else $error("configuration ready during a burst");

    // The final result of a burst is never followed at once by another result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result directly after the final one");

    // A burst only begins on an accepted request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("burst began without a request");

    // Last is only marked on a valid result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last marked without a result");

endmodule

bind dense_matrix_multiply_unit dmm_checker u_dmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_cfg_ready (o_cfg_ready),
    .o_valid     (o_valid),
    .o_last      (o_last)
);
